>>> sv/nmwu_pkg.sv
`default_nettype none

package nmwu_pkg;

   // storage geometry
   localparam int MAX_IN    = 64;
   localparam int MAX_OUT   = 64;
   localparam int W_DEPTH   = MAX_IN * MAX_OUT;
   localparam int W_AW      = $clog2(W_DEPTH);
   localparam int MEM_DEPTH = W_DEPTH + MAX_OUT;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int STRIDE_W  = 7;
   localparam int CSR_DW    = 16;

   // item kinds on the request side
   localparam logic [1:0] KIND_UPDATE = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_LR     = 2'd0;
   localparam logic [1:0] CSR_MU     = 2'd1;
   localparam logic [1:0] CSR_STRIDE = 2'd2;

   // saturation bounds, held wide enough for every intermediate sum
   localparam logic signed [34:0] SAT_HI = 35'sh0_7FFF_FFFF;
   localparam logic signed [34:0] SAT_LO = -35'sh0_8000_0000;

   typedef struct packed {
      logic [1:0]         kind;
      logic               is_bias;
      logic [5:0]         in_index;
      logic [5:0]         out_index;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight_value;
      logic signed [31:0] momentum_value;
      logic               saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_LOAD   = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // classified command between front and back
   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  addr;
      logic signed [31:0] operand;
   } cmd_type;

   // factors the back end needs from the registers
   typedef struct packed {
      logic [15:0] mu;
      logic [15:0] c;
   } cfg_type;

   // round half up from 16 extra fraction bits (floor of x/2^16 after bias)
   function automatic logic signed [33:0] rnd16(input logic signed [49:0] x);
      logic signed [49:0] t;
      t = x + 50'sd32768;
      return t[49:16];
   endfunction

   function automatic logic signed [31:0] sat_clip(input logic signed [34:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) r = SAT_HI[31:0];
      else if (x < SAT_LO) r = SAT_LO[31:0];
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic sat_over(input logic signed [34:0] x);
      return (x > SAT_HI) || (x < SAT_LO);
   endfunction

endpackage

`default_nettype wire

>>> sv/nmwu_front.sv
`default_nettype none

module nmwu_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire nmwu_pkg::req_type        req_item,
   input  wire logic [nmwu_pkg::STRIDE_W-1:0] stride,
   input  wire logic                     clear_busy,
   input  wire logic                     q_full,
   output logic                          q_push,
   output nmwu_pkg::cmd_type             q_cmd
);

   logic [nmwu_pkg::STRIDE_W-1:0] stride_eff;
   logic [12:0]                   w_addr;

   // nothing is taken while the clearing pass runs
   assign req_full = q_full || clear_busy;
   assign q_push   = req_push && !req_full;

   // stride clamped to 1..MAX_OUT
   always_comb begin
      if (stride == '0) stride_eff = nmwu_pkg::STRIDE_W'(1);
      else if (stride > nmwu_pkg::STRIDE_W'(nmwu_pkg::MAX_OUT))
         stride_eff = nmwu_pkg::STRIDE_W'(nmwu_pkg::MAX_OUT);
      else stride_eff = stride;
   end

   // row-major weight address, always within the weight space
   assign w_addr = 13'(req_item.in_index) * 13'(stride_eff) + 13'(req_item.out_index);

   // classify the item and place it in the shared address space
   always_comb begin
      case (req_item.kind)
         nmwu_pkg::KIND_UPDATE: q_cmd.op = nmwu_pkg::OP_UPDATE;
         nmwu_pkg::KIND_LOAD:   q_cmd.op = nmwu_pkg::OP_LOAD;
         default:               q_cmd.op = nmwu_pkg::OP_READ;
      endcase
      if (req_item.is_bias)
         q_cmd.addr = nmwu_pkg::ADDR_W'(nmwu_pkg::W_DEPTH)
                    + nmwu_pkg::ADDR_W'(req_item.out_index);
      else
         q_cmd.addr = nmwu_pkg::ADDR_W'(w_addr[nmwu_pkg::W_AW-1:0]);
      q_cmd.operand = req_item.operand_value;
   end

   // an item accepted must always find room in the queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!q_full && !clear_busy))
      else $error("item accepted with no room");

endmodule

`default_nettype wire

>>> sv/nmwu_queue.sv
`default_nettype none

module nmwu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_push,
   input  wire nmwu_pkg::cmd_type q_wdata,
   output logic                   q_full,
   input  wire logic              q_pop,
   output logic                   q_empty,
   output nmwu_pkg::cmd_type      q_rdata
);

   nmwu_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign q_rdata = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(q_push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) entry_ff[wr_ptr_ff] <= q_wdata;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (count_ff != 2'd2))
      else $error("command queue overflow");

endmodule

`default_nettype wire

>>> sv/nmwu_back.sv
`default_nettype none

module nmwu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nmwu_pkg::cfg_type cfg,
   input  wire logic              q_empty,
   input  wire nmwu_pkg::cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   clear_busy,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output nmwu_pkg::rsp_type      rsp_item
);

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_IDLE  = 10'b00_0000_0010,
      ST_RDOUT = 10'b00_0000_0100,
      ST_MUL1  = 10'b00_0000_1000,
      ST_MUL2  = 10'b00_0001_0000,
      ST_SUB   = 10'b00_0010_0000,
      ST_MOM   = 10'b00_0100_0000,
      ST_MUL3  = 10'b00_1000_0000,
      ST_RND   = 10'b01_0000_0000,
      ST_FIN   = 10'b10_0000_0000
   } state_type;

   // weight and momentum side by side, bias entries above the weight space
   logic [63:0] mem [nmwu_pkg::MEM_DEPTH];

   state_type                    state_ff, state_in;
   logic [nmwu_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   nmwu_pkg::cmd_type            cmd_ff, cmd_in;
   logic [63:0]                  rd_ff;
   logic signed [48:0]           prod_a_ff, prod_a_in;
   logic signed [48:0]           prod_b_ff, prod_b_in;
   logic signed [32:0]           m_mu_ff, m_mu_in;
   logic signed [32:0]           step_ff, step_in;
   logic signed [31:0]           w1_ff, w1_in;
   logic signed [31:0]           m2_ff, m2_in;
   logic signed [49:0]           prod_c_ff, prod_c_in;
   logic signed [33:0]           corr_ff, corr_in;
   logic                         flag_ff, flag_in;
   nmwu_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         mem_we, mem_re;
   logic [nmwu_pkg::ADDR_W-1:0]  mem_waddr;
   logic [63:0]                  mem_wdata;
   logic                         rsp_load, rsp_take, slot_free;
   logic signed [31:0]           rd_w, rd_m;
   logic signed [34:0]           diff, sum;
   logic signed [33:0]           rnd_a, rnd_b;
   logic signed [31:0]           w3;

   assign rd_w       = rd_ff[63:32];
   assign rd_m       = rd_ff[31:0];
   assign rsp_take   = rsp_pop && rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_take;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // shared rounding and saturation helpers
   assign rnd_a = nmwu_pkg::rnd16({prod_a_ff[48], prod_a_ff});
   assign rnd_b = nmwu_pkg::rnd16({prod_b_ff[48], prod_b_ff});
   assign diff  = (state_ff == ST_SUB)
                ? {{3{rd_w[31]}}, rd_w} - {{2{m_mu_ff[32]}}, m_mu_ff}
                : {{2{m_mu_ff[32]}}, m_mu_ff} - {{2{step_ff[32]}}, step_ff};
   assign sum   = {{3{w1_ff[31]}}, w1_ff} + {corr_ff[33], corr_ff};
   assign w3    = nmwu_pkg::sat_clip(sum);

   // sequencer: one arithmetic step per cycle, holding while the result slot is full and not popped
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      m_mu_in      = m_mu_ff;
      step_in      = step_ff;
      w1_in        = w1_ff;
      m2_in        = m2_ff;
      prod_c_in    = prod_c_ff;
      corr_in      = corr_ff;
      flag_in      = flag_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = cmd_ff.addr;
      mem_wdata    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == nmwu_pkg::ADDR_W'(nmwu_pkg::MEM_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_cmd.op)
                  nmwu_pkg::OP_LOAD: begin
                     if (slot_free) begin
                        q_pop     = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = q_cmd.addr;
                        mem_wdata = {q_cmd.operand, 32'd0};
                        rsp_load  = 1'b1;
                        rsp_in    = '{weight_value: q_cmd.operand,
                                      momentum_value: 32'sd0, saturated: 1'b0};
                     end
                  end
                  nmwu_pkg::OP_UPDATE: begin
                     q_pop    = 1'b1;
                     mem_re   = 1'b1;
                     cmd_in   = q_cmd;
                     state_in = ST_MUL1;
                  end
                  default: begin
                     q_pop    = 1'b1;
                     mem_re   = 1'b1;
                     cmd_in   = q_cmd;
                     state_in = ST_RDOUT;
                  end
               endcase
            end
         end
         ST_RDOUT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{weight_value: rd_w, momentum_value: rd_m, saturated: 1'b0};
               state_in = ST_IDLE;
            end
         end
         ST_MUL1: begin
            // m * mu
            prod_a_in = rd_m * $signed({1'b0, cfg.mu});
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            // lr*(1-mu) * g
            prod_b_in = $signed({1'b0, cfg.c}) * cmd_ff.operand;
            m_mu_in   = rnd_a[32:0];
            state_in  = ST_SUB;
         end
         ST_SUB: begin
            // w -= m*mu
            w1_in    = nmwu_pkg::sat_clip(diff);
            flag_in  = nmwu_pkg::sat_over(diff);
            step_in  = rnd_b[32:0];
            state_in = ST_MOM;
         end
         ST_MOM: begin
            // m = mu*m - step
            m2_in    = nmwu_pkg::sat_clip(diff);
            flag_in  = flag_ff | nmwu_pkg::sat_over(diff);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            // m * (1+mu)
            prod_c_in = m2_ff * $signed({1'b0, 17'h1_0000 + {1'b0, cfg.mu}});
            state_in  = ST_RND;
         end
         ST_RND: begin
            corr_in  = nmwu_pkg::rnd16(prod_c_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // w += m*(1+mu), write back and hand out the result
            if (slot_free) begin
               mem_we    = 1'b1;
               mem_wdata = {w3, m2_ff};
               rsp_load  = 1'b1;
               rsp_in    = '{weight_value: w3, momentum_value: m2_ff,
                             saturated: flag_ff | nmwu_pkg::sat_over(sum)};
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result slot occupancy
   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_take) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      m_mu_ff   <= m_mu_in;
      step_ff   <= step_in;
      w1_ff     <= w1_in;
      m2_ff     <= m2_in;
      prod_c_ff <= prod_c_in;
      corr_ff   <= corr_in;
      flag_ff   <= flag_in;
      rsp_ff    <= rsp_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= mem[q_cmd.addr];
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> rsp_pop)
      else $error("result overwritten before it was taken");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && !q_empty))
      else $error("command taken outside idle");

   a_read_follow: assert property (@(posedge clock) disable iff (reset)
      mem_re |=> (state_ff == ST_MUL1 || state_ff == ST_RDOUT))
      else $error("read data not consumed");

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_load) |=> (state_ff == ST_IDLE))
      else $error("update did not finish");

endmodule

`default_nettype wire

>>> sv/nesterov_momentum_weight_update.sv
`default_nettype none

// Nesterov momentum update engine for a 64 x row_stride weight matrix and a 64-entry
// bias vector, each entry with its momentum, all signed Q16.16 with saturation. Items
// enter through a two-entry command queue and are executed one at a time by a sequencer
// with a single store (one write and one registered read port): a load is written and
// echoed as a result, a read fetches the entry and hands it out, and an update reads,
// runs three multiplies each followed by its rounding and saturation, and writes back;
// each may wait for the result slot to be popped. After reset a clearing pass zeroes the
// whole store, during which req_full stays high. Configuration writes are taken at any
// time and csr_ready is always high; lr*(1-mu) is registered after lr and mu update.

module nesterov_momentum_weight_update (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire nmwu_pkg::req_type req_item,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output nmwu_pkg::rsp_type      rsp_item,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [nmwu_pkg::CSR_DW-1:0] csr_data
);

   logic [15:0]                   lr_ff, lr_in;
   logic [15:0]                   mu_ff, mu_in;
   logic [nmwu_pkg::STRIDE_W-1:0] stride_ff, stride_in;
   logic [15:0]                   c_ff, c_in;
   logic [32:0]                   c_prod;
   nmwu_pkg::cfg_type             cfg;
   logic                          clear_busy, q_full, q_push, q_pop, q_empty;
   nmwu_pkg::cmd_type             q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      lr_in     = lr_ff;
      mu_in     = mu_ff;
      stride_in = stride_ff;
      if (csr_valid) begin
         case (csr_index)
            nmwu_pkg::CSR_LR:     lr_in     = csr_data[15:0];
            nmwu_pkg::CSR_MU:     mu_in     = csr_data[15:0];
            nmwu_pkg::CSR_STRIDE: stride_in = csr_data[nmwu_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // lr*(1-mu) rounded to Q0.16
   assign c_prod = 33'(lr_ff) * 33'(17'h1_0000 - {1'b0, mu_ff}) + 33'd32768;
   assign c_in   = c_prod[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff     <= '0;
         mu_ff     <= '0;
         stride_ff <= nmwu_pkg::STRIDE_W'(nmwu_pkg::MAX_OUT);
         c_ff      <= '0;
      end else begin
         lr_ff     <= lr_in;
         mu_ff     <= mu_in;
         stride_ff <= stride_in;
         c_ff      <= c_in;
      end
   end

   assign cfg = '{mu: mu_ff, c: c_ff};

   nmwu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .stride     (stride_ff),
      .clear_busy (clear_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_wdata)
   );

   nmwu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_rdata (q_rdata)
   );

   nmwu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_cmd      (q_rdata),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire
